>>> rtl/float32_add_sub_assert.svh
// Assertion macros for the float32 adder.
`ifndef FLOAT32_ADD_SUB_ASSERT_SVH
`define FLOAT32_ADD_SUB_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define F32_ASSERT_CLK(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error("%m: check failed");
`define F32_ASSERT_RST(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) prop) else $error("%m: reset check failed");
`else
`define F32_ASSERT_CLK(label, clk_s, rst_s, prop)
`define F32_ASSERT_RST(label, clk_s, prop)
`endif
`endif

>>> rtl/f32as_pkg.sv
package f32as_pkg;
  localparam int DataW = 32;
  localparam int TdataInW = 72;

  localparam logic [31:0] SignBit = 32'h8000_0000;
  localparam logic [31:0] QuietBit = 32'h0040_0000;
  localparam logic [31:0] HiddenBit = 32'h0080_0000;
  localparam logic [31:0] SigMask = 32'h00ff_ffff;
  localparam logic [31:0] InfBits = 32'h7f80_0000;
  localparam logic [7:0] ExpOnes = 8'hff;
  localparam int MaxGap = 25;

  // stage 1 -> stage 2
  typedef struct packed {
    logic        spec;      // result fixed by special case
    logic [31:0] spec_val;
    logic [31:0] xs;        // signed significand, larger exp
    logic [31:0] ys;        // signed significand, pre-shift
    logic [5:0]  d;
    logic [9:0]  e;
  } s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic [31:0] hi;
    logic [31:0] lo;
    logic        sgn;
    logic [9:0]  e;
  } s2_t;
endpackage

>>> rtl/f32as_align.sv
module f32as_align (
  input  logic                 op_sub,
  input  logic [31:0]          a,
  input  logic [31:0]          b,
  output f32as_pkg::s1_t       s1
);
  import f32as_pkg::*;

  logic [31:0] x, y, xm, ym, xq, yq, xa, ya, xsg, ysg;
  logic        xsp, ysp, xn, yn;
  logic [8:0]  dd;
  logic [7:0]  ex, ey, eb;
  logic [5:0]  d;
  logic [9:0]  e;

  always_comb begin
    x = a;
    y = b ^ (op_sub ? SignBit : 32'd0);
    xm = x << 1;
    ym = y << 1;
    ex = xm[31:24];
    ey = ym[31:24];
    xsp = (ex == ExpOnes);
    ysp = (ey == ExpOnes);
    s1 = '0;
    xq = xsp ? x : y;
    yq = ysp ? y : x;
    if (xsp || ysp) begin
      s1.spec = 1'b1;
      s1.spec_val = ((xq[22:0] != 0) || (yq[22:0] != 0) || (xq != yq)) ? (xq | QuietBit) : xq;
    end else if (xm == 0 || ym == 0 || xm == ym) begin
      s1.spec = 1'b1;
      if (xm != ym) s1.spec_val = (xm == 0) ? y : x;
      else if (x != y) s1.spec_val = 32'd0;
      else if (ex == 8'd0) s1.spec_val = (x << 1) | (x & SignBit);
      else if (ex < 8'd254) s1.spec_val = x + HiddenBit;
      else s1.spec_val = (x & SignBit) | InfBits;
    end
    if (ey > ex) begin
      xa = y; ya = x; eb = ey; dd = {1'b0, ey} - {1'b0, ex};
    end else begin
      xa = x; ya = y; eb = ex; dd = {1'b0, ex} - {1'b0, ey};
    end
    if (!s1.spec && dd > 9'(MaxGap)) begin
      s1.spec = 1'b1;
      s1.spec_val = xa;
    end
    xn = xa[31];
    yn = ya[31];
    xsg = (xa | HiddenBit) & SigMask;
    ysg = (ya | HiddenBit) & SigMask;
    if (xn) xsg = 32'd0 - xsg;
    if (yn) ysg = 32'd0 - ysg;
    d = dd[5:0];
    e = {2'b0, eb};
    if ({2'b0, eb} == {1'b0, dd}) begin
      ysg = ysg ^ HiddenBit;
      if (eb == 8'd0) begin
        xsg = xsg ^ HiddenBit;
        e = e + 10'd1;
      end else begin
        d = d - 6'd1;
      end
    end
    s1.xs = xsg;
    s1.ys = ysg;
    s1.d = d;
    s1.e = e - 10'd1;
  end
endmodule

>>> rtl/f32as_sum.sv
module f32as_sum (
  input  f32as_pkg::s1_t s1,
  output f32as_pkg::s2_t s2
);
  import f32as_pkg::*;

  logic [63:0] cat, neg;
  logic [31:0] hi, lo;

  always_comb begin
    cat = {s1.ys, 32'd0};
    cat = $signed(cat) >>> s1.d;
    hi = s1.xs + cat[63:32];
    lo = cat[31:0];
    neg = 64'd0 - {hi, lo};
    s2.spec = s1.spec;
    s2.spec_val = s1.spec_val;
    s2.sgn = hi[31];
    s2.hi = hi[31] ? neg[63:32] : hi;
    s2.lo = hi[31] ? neg[31:0] : lo;
    s2.e = s1.e;
  end
endmodule

>>> rtl/f32as_norm.sv
module f32as_norm (
  input  f32as_pkg::s2_t s2,
  output logic [31:0]    res
);
  import f32as_pkg::*;

  logic [31:0] hi, lo, sg;
  logic signed [10:0] e;
  logic [10:0] ne;

  always_comb begin
    hi = s2.hi;
    lo = s2.lo;
    e = $signed({1'b0, s2.e});
    sg = s2.sgn ? SignBit : 32'd0;
    ne = 11'd0;
    res = 32'd0;
    if (s2.spec) begin
      res = s2.spec_val;
    end else if (hi >= HiddenBit) begin
      if (hi >= 32'h0100_0000) begin
        lo = {hi[0], lo[31:1]};
        hi = hi >> 1;
        e = e + 11'sd1;
      end
      if (hi >= 32'h0100_0000 || e >= 11'sd254) res = sg | InfBits;
      else begin
        hi = hi + {e[8:0], 23'd0} + {31'd0, lo[31]};
        if (lo == SignBit) hi[0] = 1'b0;
        res = hi | sg;
      end
    end else begin
      hi = {hi[30:0], lo[31]};
      lo = lo << 1;
      e = e - 11'sd1;
      if (e < 0 || hi < HiddenBit) begin
        if (hi[31:12] == 0) begin hi = hi << 12; e = e - 11'sd12; end
        if (hi[23:16] == 0) begin hi = hi << 8; e = e - 11'sd8; end
        if (hi[23:20] == 0) begin hi = hi << 4; e = e - 11'sd4; end
        if (hi[23:22] == 0) begin hi = hi << 2; e = e - 11'sd2; end
        if (hi < HiddenBit) begin hi = hi << 1; e = e - 11'sd1; end
        ne = 11'd0 - e;
        if (e >= 0) res = (hi + {e[8:0], 23'd0}) | sg;
        else res = sg | ((ne > 11'd31) ? 32'd0 : (hi >> ne[4:0]));
      end else begin
        hi = hi + {e[8:0], 23'd0} + {31'd0, lo[31]};
        if (lo == SignBit) hi[0] = 1'b0;
        res = hi | sg;
      end
    end
  end
endmodule

>>> rtl/float32_add_sub.sv
// float32_add_sub: binary32 add/subtract, round to nearest even.
// Input channel in_*: in_tdata = {right_operand, left_operand, operation}
//   packed from bit 0 (operation in bit 0), padded to 72 bits.
// Output channel out_*: out_tdata = result_bits.
// Pipeline of three register stages: align/special cases, significand add
// and negate, normalize/round into the output register.
// Each operation passes through s1_r, s2_r and out_r in that order; out_tvalid
// rises once its result is held in out_r.
// Throughput: one operation per cycle while out_tready is high; every stage advances when the stage
// after it is empty or moving.
// When out_tready is low the pipe fills and in_tready falls; nothing is
// dropped or repeated. Reset (rst_n low, synchronous) clears all valid bits.
module float32_add_sub (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [f32as_pkg::TdataInW-1:0] in_tdata,   // operation, left_operand, right_operand
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [f32as_pkg::DataW-1:0]    out_tdata   // result_bits
);
  import f32as_pkg::*;
  `include "float32_add_sub_assert.svh"

  s1_t s1_nxt, s1_r;
  s2_t s2_nxt, s2_r;
  logic [31:0] res_nxt, out_r;
  logic v1_r, v2_r, v3_r, en1, en2, en3;

  assign en3 = !v3_r || out_tready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;
  assign out_tvalid = v3_r;
  assign out_tdata = out_r;

  f32as_align u_align (.op_sub(in_tdata[0]), .a(in_tdata[32:1]), .b(in_tdata[64:33]),
                       .s1(s1_nxt));
  f32as_sum u_sum (.s1(s1_r), .s2(s2_nxt));
  f32as_norm u_norm (.s2(s2_r), .res(res_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) out_r <= res_nxt;
  end

  `F32_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_tvalid)
  `F32_ASSERT_CLK(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `F32_ASSERT_CLK(a_full_stall, clk, rst_n, v1_r && v2_r && v3_r && !out_tready |-> !in_tready)
endmodule
